// ----- hw/rtl/hdv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdv_pkg
// Types, codes and type tables shared by the handle table validator.
// ----------------------------------------------------------------------------
package hdv_pkg;

    // object type count and type codes
    localparam int NUM_TYPES = 22;
    localparam logic [4:0] OBJ_NONE     = 5'd0;
    localparam logic [4:0] OBJ_WINDOW   = 5'd1;
    localparam logic [4:0] OBJ_MENU     = 5'd2;
    localparam logic [4:0] OBJ_CURSOR   = 5'd3;
    localparam logic [4:0] OBJ_DEFERPOS = 5'd4;
    localparam logic [4:0] OBJ_HOOK     = 5'd5;
    localparam logic [4:0] OBJ_ACCEL    = 5'd8;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_WINDOW   = 3'd1;
    localparam logic [2:0] ERR_MENU     = 3'd2;
    localparam logic [2:0] ERR_CURSOR   = 3'd3;
    localparam logic [2:0] ERR_DEFERPOS = 3'd4;
    localparam logic [2:0] ERR_HOOK     = 3'd5;
    localparam logic [2:0] ERR_ACCEL    = 3'd6;
    localparam logic [2:0] ERR_GENERIC  = 3'd7;

    // configuration register indexes
    localparam logic [2:0] CFG_FIRST_HANDLE  = 3'd0;
    localparam logic [2:0] CFG_HANDLE_COUNT  = 3'd1;
    localparam logic [2:0] CFG_DESKTOP_BASE  = 3'd2;
    localparam logic [2:0] CFG_DESKTOP_LIMIT = 3'd3;
    localparam logic [2:0] CFG_CLIENT_DELTA  = 3'd4;
    localparam logic [2:0] CFG_SHARED_DELTA  = 3'd5;
    localparam logic [2:0] CFG_DEAD_MASK     = 3'd6;

    // handle parts
    localparam logic [15:0] GEN_ANY = 16'hffff;

    // input tdata layout
    localparam int IN_W      = 144;
    localparam int HANDLE_LO = 0;
    localparam int WANT_LO   = 32;
    localparam int EIDX_LO   = 37;
    localparam int ETYPE_LO  = 47;
    localparam int EGEN_LO   = 52;
    localparam int EFLAG_LO  = 68;
    localparam int EPTR_LO   = 76;

    // output tdata width
    localparam int OUT_W = 72;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [15:0] first_handle;
        logic [10:0] handle_count;
        logic [63:0] desktop_base;
        logic [63:0] desktop_limit;
        logic [63:0] client_delta;
        logic [63:0] shared_delta;
        logic [7:0]  dead_flag_mask;
    } hdv_cfg_t;

    typedef struct packed {
        logic [4:0]  etype;
        logic [15:0] generation;
        logic [7:0]  flags;
        logic [63:0] pointer;
    } hdv_entry_t;

    typedef enum logic [1:0] {
        KIND_EMPTY,
        KIND_SHARED,
        KIND_DESKTOP
    } hdv_kind_t;

    typedef struct packed {
        hdv_kind_t   kind;
        logic [2:0]  error_code;
        logic [63:0] pointer;
    } hdv_verdict_t;

    function automatic logic heap_is_shared(input logic [4:0] t);
        logic r;
        r = 1'b0;
        case (t) inside
            OBJ_CURSOR, OBJ_DEFERPOS, 5'd6, OBJ_ACCEL, [5'd12:5'd16]: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] type_error(input logic [4:0] t);
        logic [2:0] r;
        r = ERR_GENERIC;
        case (t)
            OBJ_WINDOW:   r = ERR_WINDOW;
            OBJ_MENU:     r = ERR_MENU;
            OBJ_CURSOR:   r = ERR_CURSOR;
            OBJ_DEFERPOS: r = ERR_DEFERPOS;
            OBJ_HOOK:     r = ERR_HOOK;
            OBJ_ACCEL:    r = ERR_ACCEL;
            default:      r = ERR_GENERIC;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/hdv_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdv_front
// Accepts items, owns the entry table, checks handles and hands a verdict
// for each item to the queue.
// ----------------------------------------------------------------------------
module hdv_front #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  hdv_pkg::hdv_cfg_t                cfg,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [hdv_pkg::IN_W-1:0]         s_axis_tdata,
    input  wire  [0:0]                       s_axis_tuser,
    input  wire  [hdv_pkg::Q_CNT_W-1:0]      q_count,
    output logic                             push_valid,
    output hdv_pkg::hdv_verdict_t            push_data
);
    import hdv_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [15:0] DEPTH16 = 16'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [5:0] NTYPES6 = 6'(NUM_TYPES);

    hdv_entry_t mem [TABLE_DEPTH];
    hdv_entry_t rd_data_reg;

    logic             clr_active_reg, clr_active_next;
    logic [IDX_W-1:0] clr_addr_reg, clr_addr_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_load_reg;
    logic             s1_inrange_reg;
    logic [15:0]      s1_gen_reg;
    logic [4:0]       s1_want_reg;

    logic        accept;
    logic        action;
    logic [31:0] handle;
    logic [15:0] low_word;
    logic [16:0] diff;
    logic [14:0] idx;
    logic        inrange;
    logic [9:0]  entry_index;
    logic        wr_en;
    logic [IDX_W-1:0] wr_addr;
    hdv_entry_t  wr_data;
    hdv_entry_t  load_entry;

    logic       hit;
    logic [4:0] eff;
    logic       fail;

    assign action      = s_axis_tuser[0];
    assign handle      = s_axis_tdata[HANDLE_LO +: 32];
    assign entry_index = s_axis_tdata[EIDX_LO +: 10];
    assign low_word    = handle[15:0];
    assign diff        = {1'b0, low_word} - {1'b0, cfg.first_handle};
    assign idx         = diff[15:1];
    assign inrange     = (handle != 32'd0) && !diff[16] &&
                         (idx < {4'd0, cfg.handle_count}) && ({1'b0, idx} < DEPTH16);

    assign load_entry.etype      = s_axis_tdata[ETYPE_LO +: 5];
    assign load_entry.generation = s_axis_tdata[EGEN_LO +: 16];
    assign load_entry.flags      = s_axis_tdata[EFLAG_LO +: 8];
    assign load_entry.pointer    = s_axis_tdata[EPTR_LO +: 64];

    // room for the item in flight as well as the new one
    assign s_axis_tready = !clr_active_reg &&
                           (Q_CNT_W'(q_count + Q_CNT_W'(s1_valid_reg)) < Q_CNT_W'(Q_DEPTH));
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_active_next = 1'b0;
            end
        end
        s1_valid_next = accept;
    end

    always_comb
    begin
        if (clr_active_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = accept && action && ({6'd0, entry_index} < DEPTH16);
            wr_addr = IDX_W'(entry_index);
            wr_data = load_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (accept && !action)
        begin
            rd_data_reg <= mem[idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_load_reg    <= action;
            s1_inrange_reg <= inrange;
            s1_gen_reg     <= handle[31:16];
            s1_want_reg    <= s_axis_tdata[WANT_LO +: 5];
        end
    end

    // checks on the entry read back
    always_comb
    begin
        hit = s1_inrange_reg && (rd_data_reg.etype != OBJ_NONE) &&
              (rd_data_reg.pointer != 64'd0) &&
              ((s1_gen_reg == rd_data_reg.generation) || (s1_gen_reg == 16'd0) ||
               (s1_gen_reg == GEN_ANY));
        eff = (hit && (s1_want_reg == OBJ_NONE)) ? rd_data_reg.etype : s1_want_reg;
        fail = !hit || ({1'b0, eff} >= NTYPES6) || (rd_data_reg.etype != eff) ||
               ((rd_data_reg.flags & cfg.dead_flag_mask) != 8'd0);

        push_data.kind       = KIND_EMPTY;
        push_data.error_code = ERR_NONE;
        push_data.pointer    = rd_data_reg.pointer;
        if (s1_load_reg)
        begin
            push_data.kind = KIND_EMPTY;
        end
        else if (fail)
        begin
            push_data.error_code = type_error(eff);
        end
        else if (heap_is_shared(eff))
        begin
            push_data.kind = KIND_SHARED;
        end
        else
        begin
            push_data.kind = KIND_DESKTOP;
        end
    end

    assign push_valid = s1_valid_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/hdv_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdv_queue
// Short queue of verdicts between the lookup front and the translate back.
// ----------------------------------------------------------------------------
module hdv_queue (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          push_valid,
    input  hdv_pkg::hdv_verdict_t        push_data,
    input  wire                          pop,
    output logic                         pop_valid,
    output hdv_pkg::hdv_verdict_t        pop_data,
    output logic [hdv_pkg::Q_CNT_W-1:0]  count
);
    import hdv_pkg::*;

    hdv_verdict_t slots_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic do_pop;

    assign pop_valid = (count_reg != '0);
    assign pop_data  = slots_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push_valid);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(do_pop);
        count_next  = count_reg + Q_CNT_W'(push_valid) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/hdv_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdv_back
// Translates passing entries to user pointers and holds the result item.
// ----------------------------------------------------------------------------
module hdv_back (
    input  wire                         clk,
    input  wire                         rst_n,
    input  hdv_pkg::hdv_cfg_t           cfg,
    input  wire                         pop_valid,
    input  hdv_pkg::hdv_verdict_t       pop_data,
    output logic                        pop,
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    output logic [hdv_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic [1:0]                  m_axis_tuser
);
    import hdv_pkg::*;

    logic        valid_reg, valid_next;
    logic        found_reg;
    logic        kmap_reg;
    logic [63:0] uptr_reg;
    logic [2:0]  err_reg;

    logic        found;
    logic        kmap;
    logic [63:0] uptr;
    logic [63:0] delta;
    logic        in_window;

    assign pop = pop_valid && (!valid_reg || m_axis_tready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_comb
    begin
        delta     = (pop_data.kind == KIND_SHARED) ? cfg.shared_delta : cfg.client_delta;
        in_window = (pop_data.pointer >= cfg.desktop_base) &&
                    (pop_data.pointer < cfg.desktop_limit);
        found = 1'b0;
        kmap  = 1'b0;
        uptr  = 64'd0;
        if (pop_data.kind == KIND_SHARED)
        begin
            found = 1'b1;
            if (cfg.shared_delta != 64'd0)
            begin
                uptr = pop_data.pointer - delta;
            end
        end
        else if (pop_data.kind == KIND_DESKTOP)
        begin
            found = 1'b1;
            if (in_window)
            begin
                uptr = pop_data.pointer - delta;
            end
            else
            begin
                kmap = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            found_reg <= found;
            kmap_reg  <= kmap;
            uptr_reg  <= uptr;
            err_reg   <= pop_data.error_code;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {5'd0, err_reg, uptr_reg};
    assign m_axis_tuser  = {kmap_reg, found_reg};

endmodule
`default_nettype wire

// ----- hw/rtl/handle_table_validator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// handle_table_validator
// Generational handle table: load items write entries, validate items check
// a handle and return the translated user pointer or an error code.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  contents
//  s_axis    in         s_axis_tvalid/tready       one load or validate item
//  m_axis    out        m_axis_tvalid/tready       one result per item
//  cfg       in         cfg_valid/cfg_ready        register index and value
//
//  the accepting edge reads the table into a register, the verdict then goes
//  into the queue and from there into the output register; one item per
//  cycle sustained while the output is not stalled, set by the single table
//  read port.
//  after reset the table is cleared one entry a cycle with s_axis_tready low;
//  configuration writes are taken at all times. a stalled output holds
//  input off once the items queued and in flight fill the four-entry queue.
// ----------------------------------------------------------------------------
module handle_table_validator #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // handle, want_type, entry_index, entry_type, entry_generation,
    // entry_flags, entry_pointer, zero pad
    input  wire  [143:0] s_axis_tdata,
    // action
    input  wire  [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // user_pointer, error_code, zero pad
    output logic [71:0]  m_axis_tdata,
    // found, needs_kernel_mapping
    output logic [1:0]   m_axis_tuser,
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [2:0]   cfg_index,
    input  wire  [63:0]  cfg_data
);
    import hdv_pkg::*;

    hdv_cfg_t cfg_reg, cfg_next;

    logic                 push_valid;
    hdv_verdict_t         push_data;
    logic                 pop;
    logic                 pop_valid;
    hdv_verdict_t         pop_data;
    logic [Q_CNT_W-1:0]   q_count;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FIRST_HANDLE:  cfg_next.first_handle   = cfg_data[15:0];
                CFG_HANDLE_COUNT:  cfg_next.handle_count   = cfg_data[10:0];
                CFG_DESKTOP_BASE:  cfg_next.desktop_base   = cfg_data;
                CFG_DESKTOP_LIMIT: cfg_next.desktop_limit  = cfg_data;
                CFG_CLIENT_DELTA:  cfg_next.client_delta   = cfg_data;
                CFG_SHARED_DELTA:  cfg_next.shared_delta   = cfg_data;
                CFG_DEAD_MASK:     cfg_next.dead_flag_mask = cfg_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_handle   <= 16'd32;
            cfg_reg.handle_count   <= 11'd0;
            cfg_reg.desktop_base   <= 64'd0;
            cfg_reg.desktop_limit  <= 64'd0;
            cfg_reg.client_delta   <= 64'd0;
            cfg_reg.shared_delta   <= 64'd0;
            cfg_reg.dead_flag_mask <= 8'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hdv_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_count       (q_count),
        .push_valid    (push_valid),
        .push_data     (push_data)
    );

    hdv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .count      (q_count)
    );

    hdv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .pop_valid     (pop_valid),
        .pop_data      (pop_data),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire

// ----- sim/tb_handle_table_validator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handle_table_validator
// Self-checking bench for the handle table validator. Load and validate items
// go in through the input stream, and each result is compared field by field
// with an in-bench prediction that keeps its own copy of the table and of the
// registers. The run begins with directed cases and then moves to random
// phases, each with new register settings. Both stream sides idle in random
// bursts, and the last phase runs with no idling at all.
// ----------------------------------------------------------------------------
module tb_handle_table_validator;
    import hdv_pkg::*;

    localparam int SLOTS = 1024;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_CAP = 100;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 260;
    localparam logic OP_VALIDATE = 1'b0;
    localparam logic OP_LOAD = 1'b1;
    localparam logic [2:0] CFG_SPARE = 3'd7;
    localparam logic [31:0] SHARED_HEAP_TYPES = 32'h0001_f158;

    typedef struct packed {
        logic        action;
        logic [31:0] handle;
        logic [4:0]  want;
        logic [9:0]  eidx;
        logic [4:0]  etype;
        logic [15:0] egen;
        logic [7:0]  eflags;
        logic [63:0] eptr;
    } request_t;

    typedef struct packed {
        logic        found;
        logic [63:0] user_ptr;
        logic [2:0]  err;
        logic        kmap;
    } outcome_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    wire          s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    wire  [71:0]  m_axis_tdata;
    wire  [1:0]   m_axis_tuser;
    logic         cfg_valid = 1'b0;
    wire          cfg_ready;
    logic [2:0]   cfg_index = CFG_FIRST_HANDLE;
    logic [63:0]  cfg_data = '0;

    // register copy
    logic [15:0] reg_first_handle = 16'd32;
    logic [10:0] reg_handle_count = 11'd0;
    logic [63:0] reg_desk_base = '0;
    logic [63:0] reg_desk_limit = '0;
    logic [63:0] reg_client_delta = '0;
    logic [63:0] reg_shared_delta = '0;
    logic [7:0]  reg_dead_mask = 8'd3;

    // table copy, updated as items are accepted
    bit [4:0]  tbl_type [SLOTS];
    bit [15:0] tbl_gen [SLOTS];
    bit [7:0]  tbl_flags [SLOTS];
    bit [63:0] tbl_ptr [SLOTS];

    // table as planned by the stimulus, used to build handles that hit
    bit [4:0]  plan_type [SLOTS];
    bit [15:0] plan_gen [SLOTS];

    request_t requests_pending [$];
    outcome_t outcomes_due [$];
    request_t req_on_bus;
    bit       req_taken = 1'b0;
    int       src_gap = 0;
    int       sink_gap = 0;
    int       idle_pct = 10;
    int       stall_pct = 10;
    bit       calm = 1'b0;
    int       failures = 0;
    int       quiet_cycles = 0;

    handle_table_validator #(
        .TABLE_DEPTH(SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [2:0] type_fault(input logic [4:0] eff);
        logic [2:0] code;
        code = ERR_GENERIC;
        if (eff < NUM_TYPES)
        begin
            case (eff)
                OBJ_WINDOW:   code = ERR_WINDOW;
                OBJ_MENU:     code = ERR_MENU;
                OBJ_CURSOR:   code = ERR_CURSOR;
                OBJ_DEFERPOS: code = ERR_DEFERPOS;
                OBJ_HOOK:     code = ERR_HOOK;
                OBJ_ACCEL:    code = ERR_ACCEL;
                default:      code = ERR_GENERIC;
            endcase
        end
        return code;
    endfunction

    // applies a load to the table copy, or works out the verdict of a lookup
    function automatic outcome_t lookup_outcome(input request_t rq);
        outcome_t    res;
        logic [15:0] low;
        logic [15:0] hgen;
        logic [15:0] idx;
        logic        hit;
        logic [4:0]  eff;
        logic [63:0] p;
        res = '0;
        hit = 1'b0;
        idx = '0;
        if (rq.action == OP_LOAD)
        begin
            tbl_type[rq.eidx] = rq.etype;
            tbl_gen[rq.eidx] = rq.egen;
            tbl_flags[rq.eidx] = rq.eflags;
            tbl_ptr[rq.eidx] = rq.eptr;
            return res;
        end
        if (rq.handle != 32'd0)
        begin
            low = rq.handle[15:0];
            hgen = rq.handle[31:16];
            if (low >= reg_first_handle)
            begin
                idx = (low - reg_first_handle) >> 1;
                if (idx < reg_handle_count && idx < SLOTS && tbl_type[idx] != OBJ_NONE
                    && tbl_ptr[idx] != 64'd0
                    && (hgen == tbl_gen[idx] || hgen == 16'd0 || hgen == GEN_ANY))
                    hit = 1'b1;
            end
        end
        eff = rq.want;
        if (hit && eff == OBJ_NONE)
            eff = tbl_type[idx];
        if (!hit)
        begin
            res.err = type_fault(eff);
            return res;
        end
        if (eff >= NUM_TYPES || tbl_type[idx] != eff || (tbl_flags[idx] & reg_dead_mask) != 8'd0)
        begin
            res.err = type_fault(eff);
            return res;
        end
        res.found = 1'b1;
        p = tbl_ptr[idx];
        if (SHARED_HEAP_TYPES[eff])
        begin
            if (reg_shared_delta != 64'd0)
                res.user_ptr = p - reg_shared_delta;
        end
        else if (p >= reg_desk_base && p < reg_desk_limit)
            res.user_ptr = p - reg_client_delta;
        else
            res.kmap = 1'b1;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] due, input logic [63:0] seen);
        if (due !== seen)
        begin
            failures++;
            if (failures <= REPORT_CAP)
                $error("%s: expected %h, got %h", name, due, seen);
        end
    endtask

    // input stream driver
    always @(negedge clk)
    begin : drive_items
        request_t nxt;
        if (s_axis_tvalid && !req_taken)
        begin
        end
        else if (src_gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            src_gap <= src_gap - 1;
        end
        else if (requests_pending.size() == 0)
            s_axis_tvalid <= 1'b0;
        else if (!calm && $urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            src_gap <= $urandom_range(18, 0);
        end
        else
        begin
            nxt = requests_pending.pop_front();
            req_on_bus <= nxt;
            s_axis_tvalid <= 1'b1;
            s_axis_tuser <= nxt.action;
            s_axis_tdata <= {4'b0, nxt.eptr, nxt.eflags, nxt.egen, nxt.etype, nxt.eidx,
                             nxt.want, nxt.handle};
        end
    end

    // output stream back-pressure
    always @(negedge clk)
    begin
        if (sink_gap > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end
        else if (!calm && $urandom_range(99) < stall_pct)
        begin
            m_axis_tready <= 1'b0;
            sink_gap <= $urandom_range(18, 0);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // result check, then prediction of the item taken at this edge
    always @(posedge clk)
    begin : monitor
        outcome_t seen;
        outcome_t due;
        if (m_axis_tvalid && m_axis_tready)
        begin
            seen.found = m_axis_tuser[0];
            seen.kmap = m_axis_tuser[1];
            seen.user_ptr = m_axis_tdata[63:0];
            seen.err = m_axis_tdata[66:64];
            if (outcomes_due.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_CAP)
                    $error("result with no item outstanding: tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                due = outcomes_due.pop_front();
                check_field("found", 64'(due.found), 64'(seen.found));
                check_field("user_pointer", due.user_ptr, seen.user_ptr);
                check_field("error_code", 64'(due.err), 64'(seen.err));
                check_field("needs_kernel_mapping", 64'(due.kmap), 64'(seen.kmap));
            end
        end
        if (s_axis_tvalid && s_axis_tready)
            outcomes_due.push_back(lookup_outcome(req_on_bus));
        req_taken <= s_axis_tvalid && s_axis_tready;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_handle_table_validator: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_FIRST_HANDLE:  reg_first_handle = val[15:0];
            CFG_HANDLE_COUNT:  reg_handle_count = val[10:0];
            CFG_DESKTOP_BASE:  reg_desk_base = val;
            CFG_DESKTOP_LIMIT: reg_desk_limit = val;
            CFG_CLIENT_DELTA:  reg_client_delta = val;
            CFG_SHARED_DELTA:  reg_shared_delta = val;
            CFG_DEAD_MASK:     reg_dead_mask = val[7:0];
            default:           ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (requests_pending.size() != 0 || (s_axis_tvalid && !req_taken)
               || outcomes_due.size() != 0);
    endtask

    task automatic queue_load(input logic [9:0] slot, input logic [4:0] etype,
                              input logic [15:0] egen, input logic [7:0] eflags,
                              input logic [63:0] eptr);
        request_t rq;
        rq.action = OP_LOAD;
        rq.handle = $urandom;
        rq.want = 5'($urandom_range(31));
        rq.eidx = slot;
        rq.etype = etype;
        rq.egen = egen;
        rq.eflags = eflags;
        rq.eptr = eptr;
        plan_type[slot] = etype;
        plan_gen[slot] = egen;
        requests_pending.push_back(rq);
    endtask

    task automatic queue_lookup(input logic [31:0] handle, input logic [4:0] want);
        request_t rq;
        rq.action = OP_VALIDATE;
        rq.handle = handle;
        rq.want = want;
        rq.eidx = 10'($urandom_range(SLOTS - 1));
        rq.etype = 5'($urandom_range(31));
        rq.egen = 16'($urandom_range(16'hffff));
        rq.eflags = 8'($urandom_range(255));
        rq.eptr = {$urandom, $urandom};
        requests_pending.push_back(rq);
    endtask

    initial
    begin : stimulus
        logic [15:0] fh;
        logic [10:0] cnt;
        logic [63:0] win_base;
        logic [63:0] win_span;
        logic [63:0] ptr;
        logic [15:0] hgen;
        logic [15:0] low;
        logic [4:0]  want;
        logic [4:0]  etype;
        logic [7:0]  mask;
        int          lim;
        int          idx;
        int          r;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: no entries in use
        queue_lookup(32'h0, OBJ_MENU);
        queue_lookup({16'd0, 16'd32}, OBJ_WINDOW);
        wait_idle();

        write_reg(CFG_FIRST_HANDLE, 64'd4);
        write_reg(CFG_HANDLE_COUNT, 64'd16);
        write_reg(CFG_DESKTOP_BASE, 64'h1000_0000);
        write_reg(CFG_DESKTOP_LIMIT, 64'h2000_0000);
        write_reg(CFG_CLIENT_DELTA, 64'h0f00_0000);
        write_reg(CFG_SHARED_DELTA, 64'h100);
        write_reg(CFG_DEAD_MASK, 64'd3);
        write_reg(CFG_SPARE, {$urandom, $urandom});
        queue_load(10'd0, OBJ_WINDOW, 16'd5, 8'h80, 64'h1000_0040);
        queue_load(10'd1, OBJ_CURSOR, 16'd7, 8'h00, 64'h5000);
        queue_load(10'd2, OBJ_MENU, 16'd9, 8'h00, 64'h3000_0000);
        queue_load(10'd3, OBJ_HOOK, 16'd1, 8'h01, 64'h1000_1000);
        queue_load(10'd4, 5'd23, 16'd0, 8'h00, 64'h1234);
        queue_load(10'd5, OBJ_ACCEL, 16'd2, 8'h00, 64'h0);
        queue_load(10'd1023, 5'd21, 16'hffff, 8'hff, 64'hffff_ffff_ffff_ffff);
        queue_lookup({16'd5, 16'd4}, OBJ_NONE);
        queue_lookup({16'd0, 16'd5}, OBJ_WINDOW);
        queue_lookup({16'hffff, 16'd6}, OBJ_CURSOR);
        queue_lookup({16'd9, 16'd8}, OBJ_NONE);
        queue_lookup({16'd6, 16'd4}, OBJ_NONE);
        queue_lookup({16'd5, 16'd4}, OBJ_MENU);
        queue_lookup({16'd1, 16'd10}, OBJ_HOOK);
        queue_lookup({16'd0, 16'd12}, OBJ_NONE);
        queue_lookup({16'd2, 16'd14}, OBJ_ACCEL);
        queue_lookup({16'd0, 16'd3}, OBJ_DEFERPOS);
        queue_lookup({16'd0, 16'd36}, OBJ_WINDOW);
        queue_lookup(32'hffff_ffff, 5'd31);
        queue_lookup(32'h0, OBJ_MENU);
        wait_idle();

        // whole table in use, open window, null shared translation
        write_reg(CFG_FIRST_HANDLE, 64'd0);
        write_reg(CFG_HANDLE_COUNT, 64'd1024);
        write_reg(CFG_DESKTOP_BASE, 64'd0);
        write_reg(CFG_DESKTOP_LIMIT, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_CLIENT_DELTA, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_SHARED_DELTA, 64'd0);
        write_reg(CFG_DEAD_MASK, 64'd0);
        queue_lookup({16'd7, 16'd2}, OBJ_CURSOR);
        queue_lookup({16'hffff, 16'd2046}, OBJ_NONE);
        queue_lookup({16'd1, 16'd6}, OBJ_HOOK);
        wait_idle();

        // top of the handle space maps to slot zero
        write_reg(CFG_FIRST_HANDLE, 64'hffff);
        write_reg(CFG_HANDLE_COUNT, 64'd1);
        write_reg(CFG_DEAD_MASK, 64'h7f);
        queue_lookup({16'd5, 16'hffff}, OBJ_WINDOW);
        queue_lookup({16'd5, 16'h0000}, OBJ_WINDOW);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            idle_pct = (ph == 2) ? 0 : $urandom_range(5, 30);
            stall_pct = (ph == 2) ? 0 : $urandom_range(5, 30);
            calm = (ph == RANDOM_PHASES - 1);

            case ($urandom_range(5))
                0: fh = 16'd0;
                1: fh = 16'hffff;
                default: fh = 16'($urandom_range(2000));
            endcase
            case ($urandom_range(5))
                0: cnt = 11'd0;
                1: cnt = 11'd1024;
                2: cnt = 11'($urandom_range(1024));
                default: cnt = 11'($urandom_range(1, 48));
            endcase
            if (ph == 1)
            begin
                fh = 16'd0;
                cnt = 11'd1024;
            end
            case ($urandom_range(5))
                0:
                begin
                    win_base = 64'd0;
                    win_span = 64'hffff_ffff_ffff_ffff;
                end
                1:
                begin
                    win_base = {$urandom, $urandom};
                    win_span = 64'd0;
                end
                default:
                begin
                    win_base = {$urandom, $urandom};
                    win_span = {32'd0, $urandom_range(32'hffff_ffff, 1)};
                end
            endcase
            case ($urandom_range(3))
                0: mask = 8'd0;
                1: mask = 8'hff;
                default: mask = 8'd1 << $urandom_range(7);
            endcase
            write_reg(CFG_FIRST_HANDLE, {48'd0, fh});
            write_reg(CFG_HANDLE_COUNT, {53'd0, cnt});
            write_reg(CFG_DESKTOP_BASE, win_base);
            write_reg(CFG_DESKTOP_LIMIT, win_base + win_span);
            write_reg(CFG_CLIENT_DELTA, ($urandom_range(3) == 0) ? 64'hffff_ffff_ffff_ffff
                                                                 : {$urandom, $urandom});
            write_reg(CFG_SHARED_DELTA, ($urandom_range(3) == 0) ? 64'd0
                                                                 : {$urandom, $urandom});
            write_reg(CFG_DEAD_MASK, {56'd0, mask});

            lim = (cnt == 0) ? 16 : ((cnt > 64) ? 64 : cnt);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r = $urandom_range(99);
                if (r < 30)
                begin
                    idx = ($urandom_range(3) == 0) ? $urandom_range(SLOTS - 1)
                                                   : $urandom_range(lim - 1);
                    r = $urandom_range(99);
                    if (r < 85)
                        etype = 5'($urandom_range(21, 1));
                    else if (r < 93)
                        etype = OBJ_NONE;
                    else
                        etype = 5'($urandom_range(31, 22));
                    r = $urandom_range(99);
                    if (r < 50)
                        ptr = win_base + ({$urandom, $urandom} % (win_span | 64'd1));
                    else if (r < 85)
                        ptr = {$urandom, $urandom};
                    else if (r < 95)
                        ptr = 64'd0;
                    else
                        ptr = 64'hffff_ffff_ffff_ffff;
                    queue_load(idx[9:0], etype, 16'($urandom_range(16'hffff)),
                               ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255)), ptr);
                end
                else if (r < 75)
                begin
                    // handle aimed at a slot in use, with random generation and type
                    idx = $urandom_range(lim - 1);
                    low = fh + 16'(2 * idx) + 16'($urandom_range(1));
                    r = $urandom_range(99);
                    if (r < 55)
                        hgen = plan_gen[idx];
                    else if (r < 70)
                        hgen = 16'd0;
                    else if (r < 85)
                        hgen = GEN_ANY;
                    else
                        hgen = 16'($urandom_range(16'hffff));
                    r = $urandom_range(99);
                    if (r < 45)
                        want = OBJ_NONE;
                    else if (r < 85)
                        want = plan_type[idx];
                    else if (r < 97)
                        want = 5'($urandom_range(21));
                    else
                        want = 5'($urandom_range(31, 22));
                    queue_lookup({hgen, low}, want);
                end
                else
                begin
                    want = ($urandom_range(19) == 0) ? 5'($urandom_range(31))
                                                     : 5'($urandom_range(21));
                    queue_lookup(($urandom_range(9) == 0) ? 32'd0 : 32'($urandom), want);
                end
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (failures == 0 && outcomes_due.size() == 0)
            $display("tb_handle_table_validator: clean");
        else
            $display("tb_handle_table_validator: errors");
        $finish;
    end

endmodule
